### rtl/core/dq_pkg.sv
`default_nettype none
package dq_pkg;

	localparam int DEPTH      = 64;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int DATA_W     = 32;
	localparam int POS_W      = 6;
	localparam int CMD_W      = 3;
	localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int GROUP      = 8;
	localparam int NUM_GROUPS = (DEPTH + GROUP - 1) / GROUP;

	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = CMD_W'(0);
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = CMD_W'(1);
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = CMD_W'(2);
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = CMD_W'(3);
	localparam logic [CMD_W-1:0] CMD_READ       = CMD_W'(4);

	localparam logic signed [DATA_W-1:0] MISS_VALUE = DATA_W'(-1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEL,
		S_LAST,
		S_DONE
	} state_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic             shift_r;
		logic             shift_l;
		logic             wr;
		logic [IDX_W-1:0] wr_idx;
		logic [IDX_W-1:0] res_idx;
		logic [IDX_W-1:0] last_idx;
	} dq_ctrl_t;

endpackage
`default_nettype wire

### rtl/core/dq_cell.sv
`default_nettype none
module dq_cell (
	input  logic                               clk,
	input  logic        [dq_pkg::IDX_W-1:0]    idx,
	input  dq_pkg::dq_ctrl_t                   ctrl,
	input  logic signed [dq_pkg::DATA_W-1:0]   wr_data,
	input  logic signed [dq_pkg::DATA_W-1:0]   left_in,
	input  logic signed [dq_pkg::DATA_W-1:0]   right_in,
	output logic signed [dq_pkg::DATA_W-1:0]   value,
	output logic signed [dq_pkg::DATA_W-1:0]   res_term,
	output logic signed [dq_pkg::DATA_W-1:0]   last_term
);
	import dq_pkg::*;

	logic signed [DATA_W-1:0] value_q;

	// shift right makes room at the front, shift left closes the gap after a front pop
	always_ff @(posedge clk) begin
		if (ctrl.shift_r) begin
			value_q <= left_in;
		end else if (ctrl.shift_l) begin
			value_q <= right_in;
		end else if (ctrl.wr && (ctrl.wr_idx == idx)) begin
			value_q <= wr_data;
		end
	end

	assign value     = value_q;
	assign res_term  = (ctrl.res_idx == idx) ? value_q : '0;
	assign last_term = (ctrl.last_idx == idx) ? value_q : '0;

endmodule
`default_nettype wire

### rtl/core/dq_or_tree.sv
`default_nettype none
module dq_or_tree (
	input  logic                                        clk,
	input  logic                                        en,
	input  logic [dq_pkg::DEPTH-1:0][dq_pkg::DATA_W-1:0] terms,
	output logic signed [dq_pkg::DATA_W-1:0]            sel
);
	import dq_pkg::*;

	logic [NUM_GROUPS-1:0][DATA_W-1:0] grp_d;
	logic [NUM_GROUPS-1:0][DATA_W-1:0] grp_q;

	// at most one term is nonzero, so an or picks it out
	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < DEPTH) begin
					grp_d[g] = grp_d[g] | terms[g * GROUP + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_q <= grp_d;
		end
	end

	always_comb begin
		sel = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			sel = sel | grp_q[g];
		end
	end

endmodule
`default_nettype wire

### rtl/core/double_ended_queue_top.sv
`default_nettype none
// channel   direction  handshake              payload
// command   in         cmd_valid / cmd_stall  command, item_value, position
// result    out        res_valid / res_stall  result_value, hit, dropped_full,
//                                             entry_count, is_empty, first_value, last_value
//
// one command at a time: accept, row update with the first select,
// select of the new back entry, load of the output register.
// the two registered or trees over the cell row make up the two select steps.
// arst_n clears the count and control; cell contents hold until written.
// a stalled result holds the last step; no new command is taken meanwhile.
module double_ended_queue_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_stall,
	input  logic        [dq_pkg::CMD_W-1:0]    command,
	input  logic signed [dq_pkg::DATA_W-1:0]   item_value,
	input  logic        [dq_pkg::POS_W-1:0]    position,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic signed [dq_pkg::DATA_W-1:0]   result_value,
	output logic                               hit,
	output logic                               dropped_full,
	output logic        [dq_pkg::CNT_W-1:0]    entry_count,
	output logic                               is_empty,
	output logic signed [dq_pkg::DATA_W-1:0]   first_value,
	output logic signed [dq_pkg::DATA_W-1:0]   last_value
);
	import dq_pkg::*;

	state_t state_q, state_d;

	logic        [CMD_W-1:0]  cmd_q;
	logic signed [DATA_W-1:0] val_q;
	logic        [POS_W-1:0]  pos_q;
	logic        [CNT_W-1:0]  count_q;

	logic hit_q, drop_q, take_q, miss_q;
	logic signed [DATA_W-1:0] res_val_s2;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_res_q, out_first_q, out_last_q;
	logic                     out_hit_q, out_drop_q, out_empty_q;
	logic        [CNT_W-1:0]  out_count_q;

	logic accept, load_out, in_sel, in_last;
	logic full, empty;
	logic dec_shift_r, dec_shift_l, dec_wr, dec_hit, dec_drop, dec_take, dec_miss;
	logic dec_inc, dec_dec;
	logic [IDX_W-1:0] dec_res_idx;

	dq_ctrl_t ctrl;

	logic [DEPTH-1:0][DATA_W-1:0] cell_val, res_terms, last_terms;
	logic signed [DATA_W-1:0] res_sel, last_sel;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign accept = cmd_valid && !cmd_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (cmd_valid) state_d = S_SEL;
			S_SEL:   state_d = S_LAST;
			S_LAST:  state_d = S_DONE;
			S_DONE:  if (!(out_valid_q && res_stall)) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		cmd_stall = 1'b1;
		in_sel    = 1'b0;
		in_last   = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			S_IDLE:  cmd_stall = 1'b0;
			S_SEL:   in_sel = 1'b1;
			S_LAST:  in_last = 1'b1;
			S_DONE:  load_out = !(out_valid_q && res_stall);
			default: cmd_stall = 1'b1;
		endcase
	end

	// command decode against the count before the update
	always_comb begin
		dec_shift_r = 1'b0;
		dec_shift_l = 1'b0;
		dec_wr      = 1'b0;
		dec_hit     = 1'b0;
		dec_drop    = 1'b0;
		dec_take    = 1'b0;
		dec_miss    = 1'b0;
		dec_inc     = 1'b0;
		dec_dec     = 1'b0;
		dec_res_idx = '0;
		case (cmd_q)
			CMD_PUSH_BACK: begin
				if (full) begin
					dec_drop = 1'b1;
				end else begin
					dec_wr  = 1'b1;
					dec_hit = 1'b1;
					dec_inc = 1'b1;
				end
			end
			CMD_PUSH_FRONT: begin
				if (full) begin
					dec_drop = 1'b1;
				end else begin
					dec_shift_r = 1'b1;
					dec_hit     = 1'b1;
					dec_inc     = 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					dec_miss = 1'b1;
				end else begin
					dec_res_idx = IDX_W'(count_q - CNT_W'(1));
					dec_take    = 1'b1;
					dec_hit     = 1'b1;
					dec_dec     = 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					dec_miss = 1'b1;
				end else begin
					dec_shift_l = 1'b1;
					dec_take    = 1'b1;
					dec_hit     = 1'b1;
					dec_dec     = 1'b1;
				end
			end
			CMD_READ: begin
				if (CMP_W'(pos_q) < CMP_W'(count_q)) begin
					dec_res_idx = IDX_W'(pos_q);
					dec_take    = 1'b1;
					dec_hit     = 1'b1;
				end else begin
					dec_miss = 1'b1;
				end
			end
			default: dec_miss = 1'b0;
		endcase
	end

	always_comb begin
		ctrl.shift_r  = in_sel && dec_shift_r;
		ctrl.shift_l  = in_sel && dec_shift_l;
		ctrl.wr       = in_sel && dec_wr;
		ctrl.wr_idx   = IDX_W'(count_q);
		ctrl.res_idx  = dec_res_idx;
		ctrl.last_idx = IDX_W'(count_q - CNT_W'(1));
	end

	// cell row, front entry at cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_in, right_in;
		if (i == 0) begin : g_head
			assign left_in = val_q;
		end else begin : g_body_l
			assign left_in = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_in = '0;
		end else begin : g_body_r
			assign right_in = cell_val[i+1];
		end
		dq_cell u_cell (
			.clk       (clk),
			.idx       (IDX_W'(i)),
			.ctrl      (ctrl),
			.wr_data   (val_q),
			.left_in   (left_in),
			.right_in  (right_in),
			.value     (cell_val[i]),
			.res_term  (res_terms[i]),
			.last_term (last_terms[i])
		);
	end

	dq_or_tree u_res_tree (
		.clk   (clk),
		.en    (in_sel),
		.terms (res_terms),
		.sel   (res_sel)
	);

	// sees the row after the update
	dq_or_tree u_last_tree (
		.clk   (clk),
		.en    (in_last),
		.terms (last_terms),
		.sel   (last_sel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_sel) begin
				if (dec_inc) begin
					count_q <= count_q + CNT_W'(1);
				end else if (dec_dec) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res_valid && !res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			val_q <= item_value;
			pos_q <= position;
		end
		if (in_sel) begin
			hit_q  <= dec_hit;
			drop_q <= dec_drop;
			take_q <= dec_take;
			miss_q <= dec_miss;
		end
		if (in_last) begin
			res_val_s2 <= take_q ? res_sel : (miss_q ? MISS_VALUE : '0);
		end
		if (load_out) begin
			out_res_q   <= res_val_s2;
			out_hit_q   <= hit_q;
			out_drop_q  <= drop_q;
			out_count_q <= count_q;
			out_empty_q <= empty;
			out_first_q <= empty ? MISS_VALUE : $signed(cell_val[0]);
			out_last_q  <= empty ? MISS_VALUE : last_sel;
		end
	end

	assign res_valid    = out_valid_q;
	assign result_value = out_res_q;
	assign hit          = out_hit_q;
	assign dropped_full = out_drop_q;
	assign entry_count  = out_count_q;
	assign is_empty     = out_empty_q;
	assign first_value  = out_first_q;
	assign last_value   = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_count_only_in_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_SEL) |=> $stable(count_q))
		else $error("count changed outside the update cycle");

	a_hit_or_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(hit && dropped_full) && (is_empty == (entry_count == '0)))
		else $error("inconsistent result flags");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !(res_valid && res_stall)) |=> res_valid && state_q == S_IDLE)
		else $error("result not loaded at end of command");

endmodule
`default_nettype wire

### tb/sv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dq_pkg::*;

	localparam int RANDOM_ITEMS = 1580;
	localparam int QUIET_ITEMS  = 200;
	localparam int CYCLE_LIMIT  = 250000;
	localparam int SETTLE       = 24;
	localparam int POS_MAX      = (1 << POS_W) - 1;

	// codes the block treats as no-ops
	localparam logic [CMD_W-1:0] CMD_RSVD_5 = CMD_W'(5);
	localparam logic [CMD_W-1:0] CMD_RSVD_7 = CMD_W'(7);
	localparam logic [CMD_W-1:0] CMD_RSVD_6 = CMD_W'(6);

	typedef enum int {
		TRAFFIC_FILL,
		TRAFFIC_DRAIN,
		TRAFFIC_EVEN
	} traffic_t;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     hit;
		logic                     dropped;
		logic        [CNT_W-1:0]  count;
		logic                     empty;
		logic signed [DATA_W-1:0] first;
		logic signed [DATA_W-1:0] last;
	} deque_result_t;

	class deque_shadow;
		logic signed [DATA_W-1:0] ring [DEPTH];
		int head;
		int count;
		deque_result_t expected_results[$];
		int mismatches;
		int compared;
		int stored;
		int refused;
		int empty_pops;
		int reads;
		int reads_past;
		int spares;
		int peak;

		function void note_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val,
				logic [POS_W-1:0] pos);
			deque_result_t r;
			r.value   = '0;
			r.hit     = 1'b0;
			r.dropped = 1'b0;
			case (cmd)
				CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
					if (count >= DEPTH) begin
						r.dropped = 1'b1;
						refused++;
					end else begin
						if (cmd == CMD_PUSH_FRONT) begin
							head = (head + DEPTH - 1) % DEPTH;
							ring[head] = val;
						end else begin
							ring[(head + count) % DEPTH] = val;
						end
						count++;
						r.hit = 1'b1;
						stored++;
					end
				end
				CMD_POP_BACK, CMD_POP_FRONT: begin
					if (count == 0) begin
						r.value = MISS_VALUE;
						empty_pops++;
					end else begin
						if (cmd == CMD_POP_FRONT) begin
							r.value = ring[head];
							head = (head + 1) % DEPTH;
						end else begin
							r.value = ring[(head + count - 1) % DEPTH];
						end
						count--;
						r.hit = 1'b1;
					end
				end
				CMD_READ: begin
					reads++;
					if (pos < count) begin
						r.value = ring[(head + pos) % DEPTH];
						r.hit = 1'b1;
					end else begin
						r.value = MISS_VALUE;
						reads_past++;
					end
				end
				default: spares++;
			endcase
			if (count > peak)
				peak = count;
			r.count = CNT_W'(count);
			r.empty = (count == 0);
			r.first = (count == 0) ? MISS_VALUE : ring[head];
			r.last  = (count == 0) ? MISS_VALUE : ring[(head + count - 1) % DEPTH];
			expected_results.push_back(r);
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch at result %0d: %s", compared, msg);
		endtask

		task check_result(deque_result_t got);
			deque_result_t want;
			if (expected_results.size() == 0) begin
				report("result with no command outstanding");
				return;
			end
			want = expected_results.pop_front();
			compared++;
			if (got.value !== want.value)
				report($sformatf("result_value %0d, expected %0d", got.value, want.value));
			if (got.hit !== want.hit)
				report($sformatf("hit %b, expected %b", got.hit, want.hit));
			if (got.dropped !== want.dropped)
				report($sformatf("dropped_full %b, expected %b", got.dropped, want.dropped));
			if (got.count !== want.count)
				report($sformatf("entry_count %0d, expected %0d", got.count, want.count));
			if (got.empty !== want.empty)
				report($sformatf("is_empty %b, expected %b", got.empty, want.empty));
			if (got.first !== want.first)
				report($sformatf("first_value %0d, expected %0d", got.first, want.first));
			if (got.last !== want.last)
				report($sformatf("last_value %0d, expected %0d", got.last, want.last));
		endtask
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cmd_valid;
	logic                     cmd_stall;
	logic        [CMD_W-1:0]  command;
	logic signed [DATA_W-1:0] item_value;
	logic        [POS_W-1:0]  position;
	logic                     res_valid;
	logic                     res_stall;
	logic signed [DATA_W-1:0] result_value;
	logic                     hit;
	logic                     dropped_full;
	logic        [CNT_W-1:0]  entry_count;
	logic                     is_empty;
	logic signed [DATA_W-1:0] first_value;
	logic signed [DATA_W-1:0] last_value;

	deque_shadow shadow = new();
	bit quiet = 1'b0;
	int cycle_count = 0;

	double_ended_queue_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.command      (command),
		.item_value   (item_value),
		.position     (position),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.result_value (result_value),
		.hit          (hit),
		.dropped_full (dropped_full),
		.entry_count  (entry_count),
		.is_empty     (is_empty),
		.first_value  (first_value),
		.last_value   (last_value)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// result side: compare every transfer, stall in random bursts
	initial begin : result_side
		deque_result_t got;
		int stall_left;
		stall_left = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				got.value   = result_value;
				got.hit     = hit;
				got.dropped = dropped_full;
				got.count   = entry_count;
				got.empty   = is_empty;
				got.first   = first_value;
				got.last    = last_value;
				shadow.check_result(got);
			end
			if (quiet)
				stall_left = 0;
			else if (stall_left > 0)
				stall_left--;
			else if ($urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 8);
			res_stall <= (stall_left > 0);
		end
	end

	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] val,
			input logic [POS_W-1:0] pos);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		cmd_valid  <= 1'b1;
		command    <= cmd;
		item_value <= val;
		position   <= pos;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		shadow.note_command(cmd, val, pos);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (shadow.expected_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [CMD_W-1:0] pick_command(traffic_t mode);
		int unsigned roll;
		int unsigned push_pct;
		int unsigned pop_pct;
		roll = $urandom_range(0, 99);
		push_pct = (mode == TRAFFIC_FILL) ? 80 : (mode == TRAFFIC_DRAIN) ? 5 : 40;
		pop_pct  = (mode == TRAFFIC_DRAIN) ? 80 : (mode == TRAFFIC_FILL) ? 5 : 40;
		if (roll < 3)
			return CMD_W'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
		if (roll < 3 + push_pct)
			return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
		if (roll < 3 + push_pct + pop_pct)
			return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
		return CMD_READ;
	endfunction

	initial begin : stimulus
		traffic_t mode;
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] pos;
		int sent;
		int phase_len;
		arst_n     <= 1'b0;
		cmd_valid  <= 1'b0;
		command    <= CMD_PUSH_BACK;
		item_value <= '0;
		position   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, extreme values, reads in and past range, spare codes
		send_command(CMD_POP_BACK, 32'sd5, 6'd0);
		send_command(CMD_POP_FRONT, -32'sd5, 6'd0);
		send_command(CMD_READ, '0, 6'd0);
		send_command(CMD_READ, '0, POS_W'(POS_MAX));
		send_command(CMD_RSVD_5, 32'sd77, 6'd1);
		send_command(CMD_PUSH_BACK, 32'sh7fffffff, 6'd0);
		send_command(CMD_PUSH_FRONT, 32'sh80000000, POS_W'(POS_MAX));
		send_command(CMD_PUSH_BACK, -32'sd1, 6'd0);
		send_command(CMD_PUSH_FRONT, 32'sd0, 6'd0);
		send_command(CMD_READ, '0, 6'd0);
		send_command(CMD_READ, '0, 6'd3);
		send_command(CMD_READ, '0, 6'd4);
		send_command(CMD_READ, '0, POS_W'(POS_MAX));
		send_command(CMD_RSVD_6, 32'sd1, 6'd2);
		send_command(CMD_RSVD_7, -32'sd1, 6'd3);
		send_command(CMD_POP_FRONT, '0, 6'd0);
		send_command(CMD_POP_BACK, '0, 6'd0);
		send_command(CMD_POP_FRONT, '0, 6'd0);
		send_command(CMD_POP_BACK, '0, 6'd0);
		send_command(CMD_POP_BACK, '0, 6'd0);
		send_command(CMD_PUSH_FRONT, 32'sh5a5a5a5a, 6'd0);
		send_command(CMD_POP_BACK, '0, 6'd0);
		wait_drained();

		// phases of fill, drain and balanced traffic; the first fills to overflow
		sent = 0;
		mode = TRAFFIC_FILL;
		phase_len = 120;
		while (sent < RANDOM_ITEMS) begin
			repeat (phase_len) begin
				cmd = pick_command(mode);
				if (cmd == CMD_READ && shadow.count > 0 && $urandom_range(0, 9) != 0)
					pos = POS_W'($urandom_range(0, shadow.count - 1));
				else
					pos = POS_W'($urandom_range(0, POS_MAX));
				send_command(cmd, $urandom(), pos);
				sent++;
				quiet = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
			end
			if (!quiet && $urandom_range(0, 3) == 0)
				wait_drained();
			mode = traffic_t'($urandom_range(TRAFFIC_FILL, TRAFFIC_EVEN));
			phase_len = $urandom_range(30, 120);
			if (phase_len > RANDOM_ITEMS - sent)
				phase_len = RANDOM_ITEMS - sent;
		end
		cmd_valid <= 1'b0;

		while (shadow.expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d pushes stored, %0d refused on full, %0d pops on empty, peak fill %0d",
			shadow.stored, shadow.refused, shadow.empty_pops, shadow.peak);
		$display("%0d reads (%0d past the count), %0d spare codes, %0d results, %0d mismatches",
			shadow.reads, shadow.reads_past, shadow.spares, shadow.compared, shadow.mismatches);
		if (shadow.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
